// File: hdl/floor_texture_address_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the floor texture address generator
// Shared immediate-style wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef FLOOR_TEXTURE_ADDRESS_GENERATOR_UNIT_MACROS_SVH
`define FLOOR_TEXTURE_ADDRESS_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FTAG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FTAG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ftag_pkg.sv
// ----------------------------------------------------------------------------
// ftag_pkg
// Shared types and constants of the floor texture address generator.
// ----------------------------------------------------------------------------
package ftag_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_CAM_POS_X   = 3'd0;
	localparam logic [2:0] REG_CAM_POS_Y   = 3'd1;
	localparam logic [2:0] REG_VIEW_DIR_X  = 3'd2;
	localparam logic [2:0] REG_VIEW_DIR_Y  = 3'd3;
	localparam logic [2:0] REG_CAM_PLANE_X = 3'd4;
	localparam logic [2:0] REG_CAM_PLANE_Y = 3'd5;
	localparam logic [2:0] REG_SCREEN_COLS = 3'd6;
	localparam logic [2:0] REG_SCREEN_ROWS = 3'd7;

	// Operand width of the multiplier side of the shared unit
	localparam int unsigned OPB_W = 19;

	// Kind codes of an input transaction
	localparam logic KIND_ROW   = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_RD,
		ST_MUL_SX,
		ST_DIV_SX,
		ST_MUL_SY,
		ST_DIV_SY,
		ST_MUL_FX,
		ST_MUL_FY
	} seq_state_t;

endpackage

// File: hdl/floor_texture_address_generator_unit.sv
// ----------------------------------------------------------------------------
// floor_texture_address_generator_unit
// Floor casting address generator: row setup through a shared iterative
// multiply/divide unit, then one framebuffer/texture offset pair per pixel.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   kind, row_index
// out       output     out_valid / out_ready dst_offset, src_offset, tex_col,
//                                            tex_row, row_end, bad_row
// cfg       input      cfg_we (no wait)      cfg_index, cfg_data
//
// A pixel transaction loads the output register directly; pixels flow back to
// back while the output register drains. A row start below the horizon runs
// seven operations on the shared one-bit-per-cycle unit: three divides of PW
// bits and four multiplies of 19 bits, each launched and then closed by a done
// pulse (PW = FRAC_BITS + 31). A row at or above the horizon runs no setup.
// in_ready is low during row setup and while a result waits that out_ready
// does not take. Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
`include "floor_texture_address_generator_unit_macros.svh"

module floor_texture_address_generator_unit #(
	parameter int unsigned TEX_LOG2_W   = 6,
	parameter int unsigned TEX_LOG2_H   = 6,
	parameter int unsigned TEX_BYTES    = 4,
	parameter int unsigned SCREEN_BYTES = 4,
	parameter int unsigned LINE_BYTES   = 8192,
	parameter int unsigned FRAC_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [10:0] row_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] dst_offset,
	output logic [13:0] src_offset,
	output logic [5:0]  tex_col,
	output logic [5:0]  tex_row,
	output logic        row_end,
	output logic        bad_row
);

	localparam int unsigned RDW = 12 + FRAC_BITS;
	localparam int unsigned PW  = RDW + ftag_pkg::OPB_W;
	localparam int unsigned BW  = ftag_pkg::OPB_W;
	localparam int unsigned WW  = FRAC_BITS + 10;

	// Configuration registers
	logic [23:0]        cam_pos_x_q, cam_pos_y_q;
	logic signed [17:0] view_dir_x_q, view_dir_y_q, cam_plane_x_q, cam_plane_y_q;
	logic [11:0]        screen_cols_q, screen_rows_q;

	// Row state
	logic [31:0] pos_x_q, pos_y_q, step_x_q, step_y_q;
	logic [10:0] cur_row_q, pix_col_q;
	logic        invalid_q;
	logic [11:0] p2_q;
	logic [RDW-1:0] rd_q;
	logic [PW-1:0]  prod_q;

	// Sequencer
	ftag_pkg::seq_state_t state_q, state_d;
	logic                 launched_q;
	ftag_pkg::alu_req_t   alu_req;
	ftag_pkg::alu_status_t alu_st;
	logic [PW-1:0]        alu_a, alu_res;
	logic [BW-1:0]        alu_b;
	logic                 op_neg;

	// Output register
	logic        out_valid_q;
	logic [23:0] dst_q;
	logic [13:0] src_q;
	logic [5:0]  tcol_q, trow_q;
	logic        end_q, bad_q;

	function automatic logic [BW-1:0] mag(input logic signed [BW:0] v);
		logic [BW:0] n;
		n = v[BW] ? (~v + (BW+1)'(1)) : v;
		return n[BW-1:0];
	endfunction

	logic              in_acc, row_acc, pix_acc;
	logic signed [12:0] p_s;
	logic signed [BW:0] px2_s, py2_s, dpx_s, dpy_s;
	logic [11:0]       cols_eff;
	logic [PW-1:0]     prod_sh;
	logic [31:0]       q32, q32_s;

	assign in_ready = (state_q == ftag_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign row_acc  = in_acc && (kind == ftag_pkg::KIND_ROW);
	assign pix_acc  = in_acc && (kind == ftag_pkg::KIND_PIXEL);

	// Row offset below the horizon and signed operands
	always_comb begin
		p_s      = $signed({2'b00, row_index}) - $signed({2'b00, screen_rows_q[11:1]});
		px2_s    = {cam_plane_x_q[17], cam_plane_x_q, 1'b0};
		py2_s    = {cam_plane_y_q[17], cam_plane_y_q, 1'b0};
		dpx_s    = {{2{view_dir_x_q[17]}}, view_dir_x_q}
			- {{2{cam_plane_x_q[17]}}, cam_plane_x_q};
		dpy_s    = {{2{view_dir_y_q[17]}}, view_dir_y_q}
			- {{2{cam_plane_y_q[17]}}, cam_plane_y_q};
		cols_eff = (screen_cols_q == 12'd0) ? 12'd1 : screen_cols_q;
		prod_sh  = alu_res >> FRAC_BITS;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ftag_pkg::ST_IDLE:
				if (row_acc && (p_s > 13'sd0))
					state_d = ftag_pkg::ST_DIV_RD;
			ftag_pkg::ST_DIV_RD: if (alu_st.done) state_d = ftag_pkg::ST_MUL_SX;
			ftag_pkg::ST_MUL_SX: if (alu_st.done) state_d = ftag_pkg::ST_DIV_SX;
			ftag_pkg::ST_DIV_SX: if (alu_st.done) state_d = ftag_pkg::ST_MUL_SY;
			ftag_pkg::ST_MUL_SY: if (alu_st.done) state_d = ftag_pkg::ST_DIV_SY;
			ftag_pkg::ST_DIV_SY: if (alu_st.done) state_d = ftag_pkg::ST_MUL_FX;
			ftag_pkg::ST_MUL_FX: if (alu_st.done) state_d = ftag_pkg::ST_MUL_FY;
			ftag_pkg::ST_MUL_FY: if (alu_st.done) state_d = ftag_pkg::ST_IDLE;
			default: state_d = ftag_pkg::ST_IDLE;
		endcase
	end

	// Unit request and operand selection
	always_comb begin
		alu_req.start = (state_q != ftag_pkg::ST_IDLE) && !launched_q;
		alu_req.op    = ftag_pkg::ALU_MUL;
		alu_a         = PW'(rd_q);
		alu_b         = '0;
		op_neg        = 1'b0;
		unique case (state_q)
			ftag_pkg::ST_IDLE: ;
			ftag_pkg::ST_DIV_RD: begin
				alu_req.op = ftag_pkg::ALU_DIV;
				alu_a      = PW'(screen_rows_q) << FRAC_BITS;
				alu_b      = BW'(p2_q);
			end
			ftag_pkg::ST_MUL_SX: alu_b = mag(px2_s);
			ftag_pkg::ST_DIV_SX: begin
				alu_req.op = ftag_pkg::ALU_DIV;
				alu_a      = prod_q >> FRAC_BITS;
				alu_b      = BW'(cols_eff);
				op_neg     = px2_s[BW];
			end
			ftag_pkg::ST_MUL_SY: alu_b = mag(py2_s);
			ftag_pkg::ST_DIV_SY: begin
				alu_req.op = ftag_pkg::ALU_DIV;
				alu_a      = prod_q >> FRAC_BITS;
				alu_b      = BW'(cols_eff);
				op_neg     = py2_s[BW];
			end
			ftag_pkg::ST_MUL_FX: begin
				alu_b  = mag(dpx_s);
				op_neg = dpx_s[BW];
			end
			ftag_pkg::ST_MUL_FY: begin
				alu_b  = mag(dpy_s);
				op_neg = dpy_s[BW];
			end
			default: ;
		endcase
	end

	// Signed 32-bit result of divides and shifted products
	always_comb begin
		q32 = ((state_q == ftag_pkg::ST_MUL_FX) || (state_q == ftag_pkg::ST_MUL_FY))
			? prod_sh[31:0] : alu_res[31:0];
		q32_s = op_neg ? (32'd0 - q32) : q32;
	end

	ftag_alu #(
		.PW(PW)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (alu_a),
		.opb    (alu_b),
		.status (alu_st),
		.res    (alu_res)
	);

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ftag_pkg::ST_IDLE;
			launched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (alu_st.done)
				launched_q <= 1'b0;
			else if (alu_req.start)
				launched_q <= 1'b1;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_pos_x_q   <= 24'd131072;
			cam_pos_y_q   <= 24'd131072;
			view_dir_x_q  <= -18'sd65536;
			view_dir_y_q  <= 18'sd0;
			cam_plane_x_q <= 18'sd0;
			cam_plane_y_q <= 18'sd43253;
			screen_cols_q <= 12'd640;
			screen_rows_q <= 12'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ftag_pkg::REG_CAM_POS_X:   cam_pos_x_q   <= cfg_data;
				ftag_pkg::REG_CAM_POS_Y:   cam_pos_y_q   <= cfg_data;
				ftag_pkg::REG_VIEW_DIR_X:  view_dir_x_q  <= cfg_data[17:0];
				ftag_pkg::REG_VIEW_DIR_Y:  view_dir_y_q  <= cfg_data[17:0];
				ftag_pkg::REG_CAM_PLANE_X: cam_plane_x_q <= cfg_data[17:0];
				ftag_pkg::REG_CAM_PLANE_Y: cam_plane_y_q <= cfg_data[17:0];
				ftag_pkg::REG_SCREEN_COLS: screen_cols_q <= cfg_data[11:0];
				ftag_pkg::REG_SCREEN_ROWS: screen_rows_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Pixel datapath
	logic [10:0]   col_n;
	logic [WW-1:0] wide_x, wide_y;
	logic [9:0]    tx, ty;
	logic [31:0]   src_w;
	logic [23:0]   dst_w;

	always_comb begin
		col_n  = pix_col_q + 11'd1;
		wide_x = {pos_x_q[FRAC_BITS-1:0], 10'd0};
		wide_y = {pos_y_q[FRAC_BITS-1:0], 10'd0};
		tx     = 10'(wide_x >> (WW - TEX_LOG2_W));
		ty     = 10'(wide_y >> (WW - TEX_LOG2_H));
		dst_w  = 24'(cur_row_q) * 24'(LINE_BYTES) + 24'(col_n) * 24'(SCREEN_BYTES);
		src_w  = ((32'(ty) << TEX_LOG2_W) + 32'(tx)) * 32'(TEX_BYTES);
	end

	// Row state: setup on row start, step on each pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			step_x_q  <= '0;
			step_y_q  <= '0;
			cur_row_q <= '0;
			pix_col_q <= '0;
			invalid_q <= 1'b1;
			p2_q      <= '0;
			rd_q      <= '0;
			prod_q    <= '0;
		end else begin
			if (row_acc) begin
				cur_row_q <= row_index;
				pix_col_q <= '0;
				p2_q      <= {p_s[10:0], 1'b0};
				invalid_q <= !(p_s > 13'sd0);
				if (!(p_s > 13'sd0)) begin
					pos_x_q  <= '0;
					pos_y_q  <= '0;
					step_x_q <= '0;
					step_y_q <= '0;
				end
			end
			if (pix_acc) begin
				pix_col_q <= col_n;
				if (!invalid_q) begin
					pos_x_q <= pos_x_q + step_x_q;
					pos_y_q <= pos_y_q + step_y_q;
				end
			end
			if (alu_st.done) begin
				unique case (state_q)
					ftag_pkg::ST_DIV_RD: rd_q <= alu_res[RDW-1:0];
					ftag_pkg::ST_MUL_SX,
					ftag_pkg::ST_MUL_SY: prod_q <= alu_res;
					ftag_pkg::ST_DIV_SX: step_x_q <= q32_s;
					ftag_pkg::ST_DIV_SY: step_y_q <= q32_s;
					ftag_pkg::ST_MUL_FX: pos_x_q <= {8'd0, cam_pos_x_q} + q32_s;
					ftag_pkg::ST_MUL_FY: pos_y_q <= {8'd0, cam_pos_y_q} + q32_s;
					default: ;
				endcase
			end
		end
	end

	// Output register: load on pixel, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pix_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			dst_q  <= invalid_q ? 24'd0 : dst_w;
			src_q  <= invalid_q ? 14'd0 : src_w[13:0];
			tcol_q <= invalid_q ? 6'd0 : tx[5:0];
			trow_q <= invalid_q ? 6'd0 : ty[5:0];
			end_q  <= ({1'b0, col_n} == (screen_cols_q - 12'd1));
			bad_q  <= invalid_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign dst_offset = dst_q;
	assign src_offset = src_q;
	assign tex_col    = tcol_q;
	assign tex_row    = trow_q;
	assign row_end    = end_q;
	assign bad_row    = bad_q;

	`FTAG_ASSERT_NOW(a_idle_unit_free, state_q == ftag_pkg::ST_IDLE, !alu_st.busy, "unit busy while idle")
	`FTAG_ASSERT_NOW(a_bad_row_zero, out_valid_q && bad_q, dst_q == 24'd0 && src_q == 14'd0, "bad row gives nonzero offsets")
	`FTAG_ASSERT_NEXT(a_setup_blocks, state_q != ftag_pkg::ST_IDLE && !alu_st.done, !in_ready, "input taken during row setup")
	`FTAG_ASSERT_NEXT(a_bad_start_stays, row_acc && !(p_s > 13'sd0), state_q == ftag_pkg::ST_IDLE && invalid_q, "bad row started setup")

endmodule

// File: hdl/ftag_alu.sv
// ----------------------------------------------------------------------------
// ftag_alu
// Shared one-bit-per-cycle unit: shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module ftag_alu #(
	parameter int unsigned PW = 47
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ftag_pkg::alu_req_t            req,
	input  logic [PW-1:0]                 opa,
	input  logic [ftag_pkg::OPB_W-1:0]    opb,
	output ftag_pkg::alu_status_t         status,
	output logic [PW-1:0]                 res
);

	localparam int unsigned BW  = ftag_pkg::OPB_W;
	localparam int unsigned CW  = $clog2(PW + 1);

	ftag_pkg::alu_op_t op_q;
	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [PW-1:0]     acc_q;
	logic [PW-1:0]     sh_q;
	logic [BW-1:0]     opb_q;
	logic [BW:0]       rem_q;

	logic [BW:0]       rem_sh;
	logic              qbit;
	logic [BW:0]       rem_nx;
	logic [CW-1:0]     last_cnt;

	// Divide step: shift in the next dividend bit, subtract when it fits
	always_comb begin
		rem_sh = {rem_q[BW-1:0], sh_q[PW-1]};
		qbit   = (rem_sh >= {1'b0, opb_q});
		rem_nx = qbit ? (rem_sh - {1'b0, opb_q}) : rem_sh;
		last_cnt = (op_q == ftag_pkg::ALU_DIV) ? CW'(PW - 1) : CW'(BW - 1);
	end

	// Control: run the iteration count, pulse done after the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ftag_pkg::ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then one bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			sh_q  <= opa;
			opb_q <= opb;
			rem_q <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				ftag_pkg::ALU_MUL: begin
					if (opb_q[0])
						acc_q <= acc_q + sh_q;
					sh_q  <= {sh_q[PW-2:0], 1'b0};
					opb_q <= {1'b0, opb_q[BW-1:1]};
				end
				ftag_pkg::ALU_DIV: begin
					rem_q <= rem_nx;
					sh_q  <= {sh_q[PW-2:0], qbit};
				end
				default: ;
			endcase
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign res = (op_q == ftag_pkg::ALU_DIV) ? sh_q : acc_q;

endmodule
